// ===== src/bcu_pkg.sv =====
`timescale 1ns / 1ps
package bcu_pkg;

  localparam int DW        = 32;
  localparam int DIV_STEPS = 32;
  localparam int LATENCY   = 77;

  localparam logic [1:0] REG_TEMP_CAL    = 2'd0;
  localparam logic [1:0] REG_PRESS_CAL_A = 2'd1;
  localparam logic [1:0] REG_PRESS_CAL_B = 2'd2;
  localparam logic [1:0] REG_OSS         = 2'd3;

  localparam logic [31:0] B5_OFFSET  = 32'd4000;
  localparam logic [31:0] X3_OFFSET  = 32'd32768;
  localparam logic [31:0] STEP_BASE  = 32'd50000;
  localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
  localparam logic [31:0] K_SQ       = 32'd3038;
  localparam logic [31:0] K_LIN      = 32'hFFFF_E343;
  localparam logic [31:0] K_ROUND    = 32'd3791;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

endpackage

// ===== src/barometric_compensation_unit.sv =====
`timescale 1ns / 1ps
// Items pass stages a and b, a divider, stages c to j, a divider, k to m.
// Throughput: one item per cycle; busy stays low, start is always taken.
// The two 32-step restoring dividers set the latency.
// Synchronous active-low reset clears the valid pipe and restores the
// calibration registers (oversampling to 3, the others to zero).
module barometric_compensation_unit import bcu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        in_raw_temperature,
  input  logic [23:0]        in_raw_pressure,
  output logic               out_valid,
  output logic signed [15:0] out_temp_tenths,
  output logic [31:0]        out_pressure_pa,
  output logic               out_div_error,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);

  logic [63:0] temp_cal_r;
  logic [63:0] press_cal_a_r;
  logic [31:0] press_cal_b_r;
  logic [1:0]  oss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r    <= '0;
      press_cal_a_r <= '0;
      press_cal_b_r <= '0;
      oss_r         <= 2'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP_CAL:    temp_cal_r    <= cfg_wdata;
        REG_PRESS_CAL_A: press_cal_a_r <= cfg_wdata;
        REG_PRESS_CAL_B: press_cal_b_r <= cfg_wdata[31:0];
        REG_OSS:         oss_r         <= cfg_wdata[1:0];
        default:         oss_r         <= oss_r;
      endcase
    end
  end

  logic [31:0] ac5, ac6, mc, md, ac1, ac2, ac3, ac4, b1, b2;
  assign ac5 = {16'b0, temp_cal_r[15:0]};
  assign ac6 = {16'b0, temp_cal_r[31:16]};
  assign mc  = sx16(temp_cal_r[47:32]);
  assign md  = sx16(temp_cal_r[63:48]);
  assign ac1 = sx16(press_cal_a_r[15:0]);
  assign ac2 = sx16(press_cal_a_r[31:16]);
  assign ac3 = sx16(press_cal_a_r[47:32]);
  assign ac4 = {16'b0, press_cal_a_r[63:48]};
  assign b1  = sx16(press_cal_b_r[15:0]);
  assign b2  = sx16(press_cal_b_r[31:16]);

  assign busy = 1'b0;

  // stage a
  logic        va_r;
  logic [31:0] prod_a_r;
  logic [23:0] raw_a_r;
  logic [31:0] diff_a;
  assign diff_a = {16'b0, in_raw_temperature} - ac6;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= start && !busy;
    end
    prod_a_r <= diff_a * ac5;
    raw_a_r  <= in_raw_pressure;
  end

  // stage b
  logic        vb_r;
  logic [31:0] x1_b_r, ma_b_r, mb_b_r;
  logic        neg_b_r, zero_b_r;
  logic [23:0] raw_b_r;
  logic [31:0] x1_b, den_b, num_b;
  assign x1_b  = $signed(prod_a_r) >>> 15;
  assign den_b = x1_b + md;
  assign num_b = mc << 11;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
    x1_b_r   <= x1_b;
    ma_b_r   <= num_b[31] ? 32'd0 - num_b : num_b;
    mb_b_r   <= den_b[31] ? 32'd0 - den_b : den_b;
    neg_b_r  <= num_b[31] ^ den_b[31];
    zero_b_r <= den_b == 32'd0;
    raw_b_r  <= raw_a_r;
  end

  localparam int P1W = 32 + 1 + 1 + 24;
  logic           v_d1;
  logic [31:0]    q_d1;
  logic [P1W-1:0] pay_d1;

  bcu_div #(.PW(P1W)) u_div_t (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vb_r),
    .in_num    (ma_b_r),
    .in_den    (mb_b_r),
    .in_pay    ({x1_b_r, neg_b_r, zero_b_r, raw_b_r}),
    .out_valid (v_d1),
    .out_quo   (q_d1),
    .out_pay   (pay_d1)
  );

  // stage c
  logic        vc_r, err_c_r;
  logic [31:0] b5_c_r;
  logic [23:0] raw_c_r;
  logic [31:0] x2_c;
  assign x2_c = pay_d1[25] ? 32'd0 - q_d1 : q_d1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= v_d1;
    end
    b5_c_r  <= pay_d1[57:26] + x2_c;
    err_c_r <= pay_d1[24];
    raw_c_r <= pay_d1[23:0];
  end

  // stage d
  logic        vd_r, err_d_r;
  logic [15:0] tt_d_r;
  logic [31:0] psq_d_r, pa2_d_r, pa3_d_r;
  logic [23:0] raw_d_r;
  logic signed [31:0] t_d;
  logic [31:0] b6_d;
  logic [15:0] tt_d;
  assign t_d  = $signed(b5_c_r + 32'd8) >>> 4;
  assign b6_d = b5_c_r - B5_OFFSET;
  always_comb begin
    if (t_d < -32'sd32768) begin
      tt_d = 16'h8000;
    end else if (t_d > 32'sd32767) begin
      tt_d = 16'h7FFF;
    end else begin
      tt_d = t_d[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else begin
      vd_r <= vc_r;
    end
    err_d_r <= err_c_r;
    tt_d_r  <= tt_d;
    psq_d_r <= b6_d * b6_d;
    pa2_d_r <= ac2 * b6_d;
    pa3_d_r <= ac3 * b6_d;
    raw_d_r <= raw_c_r;
  end

  // stage e
  logic        ve_r, err_e_r;
  logic [15:0] tt_e_r;
  logic [31:0] sq_e_r, x2a_e_r, x1c_e_r;
  logic [23:0] raw_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else begin
      ve_r <= vd_r;
    end
    err_e_r <= err_d_r;
    tt_e_r  <= tt_d_r;
    sq_e_r  <= $signed(psq_d_r) >>> 12;
    x2a_e_r <= $signed(pa2_d_r) >>> 11;
    x1c_e_r <= $signed(pa3_d_r) >>> 13;
    raw_e_r <= raw_d_r;
  end

  // stage f
  logic        vf_r, err_f_r;
  logic [15:0] tt_f_r;
  logic [31:0] pb2_f_r, pb1_f_r, x2a_f_r, x1c_f_r;
  logic [23:0] raw_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else begin
      vf_r <= ve_r;
    end
    err_f_r <= err_e_r;
    tt_f_r  <= tt_e_r;
    pb2_f_r <= b2 * sq_e_r;
    pb1_f_r <= b1 * sq_e_r;
    x2a_f_r <= x2a_e_r;
    x1c_f_r <= x1c_e_r;
    raw_f_r <= raw_e_r;
  end

  // stage g
  logic        vg_r, err_g_r;
  logic [15:0] tt_g_r;
  logic [31:0] b3_g_r, t4_g_r;
  logic [23:0] raw_g_r;
  logic [31:0] x3_g, sh_g, x3b_g;
  assign x3_g  = $unsigned($signed(pb2_f_r) >>> 11) + x2a_f_r;
  assign sh_g  = ((ac1 << 2) + x3_g) << oss_r;
  assign x3b_g = $signed(x1c_f_r + $unsigned($signed(pb1_f_r) >>> 16) + 32'd2) >>> 2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
    end else begin
      vg_r <= vf_r;
    end
    err_g_r <= err_f_r;
    tt_g_r  <= tt_f_r;
    b3_g_r  <= $signed(sh_g + 32'd2) >>> 2;
    t4_g_r  <= x3b_g + X3_OFFSET;
    raw_g_r <= raw_f_r;
  end

  // stage h
  logic        vh_r, err_h_r;
  logic [15:0] tt_h_r;
  logic [31:0] b4_h_r, dif_h_r;
  logic [31:0] pb4_h, up_h;
  assign pb4_h = ac4 * t4_g_r;
  assign up_h  = {8'b0, raw_g_r} >> (4'd8 - {2'b0, oss_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vh_r <= 1'b0;
    end else begin
      vh_r <= vg_r;
    end
    err_h_r <= err_g_r;
    tt_h_r  <= tt_g_r;
    b4_h_r  <= pb4_h >> 15;
    dif_h_r <= up_h - b3_g_r;
  end

  // stage i
  logic        vi_r, err_i_r;
  logic [15:0] tt_i_r;
  logic [31:0] b4_i_r, b7_i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vi_r <= 1'b0;
    end else begin
      vi_r <= vh_r;
    end
    err_i_r <= err_h_r || (b4_h_r == 32'd0);
    tt_i_r  <= tt_h_r;
    b4_i_r  <= b4_h_r;
    b7_i_r  <= dif_h_r * (STEP_BASE >> oss_r);
  end

  // stage j
  logic        vj_r, err_j_r, shl_j_r;
  logic [15:0] tt_j_r;
  logic [31:0] b4_j_r, num_j_r;
  logic        small_j;
  assign small_j = b7_i_r < SIGN_BIT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vj_r <= 1'b0;
    end else begin
      vj_r <= vi_r;
    end
    err_j_r <= err_i_r;
    tt_j_r  <= tt_i_r;
    b4_j_r  <= b4_i_r;
    num_j_r <= small_j ? b7_i_r << 1 : b7_i_r;
    shl_j_r <= !small_j;
  end

  localparam int P2W = 1 + 1 + 16;
  logic           v_d2;
  logic [31:0]    q_d2;
  logic [P2W-1:0] pay_d2;

  bcu_div #(.PW(P2W)) u_div_p (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vj_r),
    .in_num    (num_j_r),
    .in_den    (b4_j_r),
    .in_pay    ({shl_j_r, err_j_r, tt_j_r}),
    .out_valid (v_d2),
    .out_quo   (q_d2),
    .out_pay   (pay_d2)
  );

  // stage k
  logic        vk_r, err_k_r;
  logic [15:0] tt_k_r;
  logic [31:0] p_k_r, sqp_k_r, lin_k_r;
  logic [31:0] p_k, pp_k;
  assign p_k  = pay_d2[17] ? q_d2 << 1 : q_d2;
  assign pp_k = $signed(p_k) >>> 8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vk_r <= 1'b0;
    end else begin
      vk_r <= v_d2;
    end
    err_k_r <= pay_d2[16];
    tt_k_r  <= pay_d2[15:0];
    p_k_r   <= p_k;
    sqp_k_r <= pp_k * pp_k;
    lin_k_r <= K_LIN * p_k;
  end

  // stage l
  logic        vl_r, err_l_r;
  logic [15:0] tt_l_r;
  logic [31:0] p_l_r, psq_l_r, x2_l_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r <= 1'b0;
    end else begin
      vl_r <= vk_r;
    end
    err_l_r <= err_k_r;
    tt_l_r  <= tt_k_r;
    p_l_r   <= p_k_r;
    psq_l_r <= sqp_k_r * K_SQ;
    x2_l_r  <= $signed(lin_k_r) >>> 16;
  end

  // stage m: output register
  logic        vm_r, err_m_r;
  logic [15:0] tt_m_r;
  logic [31:0] p_m_r;
  logic [31:0] x1_m, corr_m;
  assign x1_m   = $signed(psq_l_r) >>> 16;
  assign corr_m = $signed(x1_m + x2_l_r + K_ROUND) >>> 4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else begin
      vm_r <= vl_r;
    end
    err_m_r <= err_l_r;
    tt_m_r  <= err_l_r ? 16'd0 : tt_l_r;
    p_m_r   <= err_l_r ? 32'd0 : p_l_r + corr_m;
  end

  assign out_valid       = vm_r;
  assign out_temp_tenths = tt_m_r;
  assign out_pressure_pa = p_m_r;
  assign out_div_error   = err_m_r;

endmodule

// ===== src/bcu_div.sv =====
`timescale 1ns / 1ps
module bcu_div import bcu_pkg::*; #(
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [DW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [DW-1:0] out_quo,
  output logic [PW-1:0] out_pay
);

  logic          v_r   [1:DIV_STEPS];
  logic [DW-1:0] rem_r [1:DIV_STEPS];
  logic [DW-1:0] nq_r  [1:DIV_STEPS];
  logic [DW-1:0] den_r [1:DIV_STEPS];
  logic [PW-1:0] pay_r [1:DIV_STEPS];

  logic          v_s   [0:DIV_STEPS-1];
  logic [DW-1:0] rem_s [0:DIV_STEPS-1];
  logic [DW-1:0] nq_s  [0:DIV_STEPS-1];
  logic [DW-1:0] den_s [0:DIV_STEPS-1];
  logic [PW-1:0] pay_s [0:DIV_STEPS-1];

  always_comb begin
    v_s[0]   = in_valid;
    rem_s[0] = '0;
    nq_s[0]  = in_num;
    den_s[0] = in_den;
    pay_s[0] = in_pay;
    for (int i = 1; i < DIV_STEPS; i++) begin
      v_s[i]   = v_r[i];
      rem_s[i] = rem_r[i];
      nq_s[i]  = nq_r[i];
      den_s[i] = den_r[i];
      pay_s[i] = pay_r[i];
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rem_s[i], nq_s[i][DW-1]};
    assign ge    = trial >= {1'b0, den_s[i]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_s[i];
      end
      rem_r[i+1] <= ge ? DW'(trial - {1'b0, den_s[i]}) : trial[DW-1:0];
      nq_r[i+1]  <= {nq_s[i][DW-2:0], ge};
      den_r[i+1] <= den_s[i];
      pay_r[i+1] <= pay_s[i];
    end
  end

  assign out_valid = v_r[DIV_STEPS];
  assign out_quo   = nq_r[DIV_STEPS];
  assign out_pay   = pay_r[DIV_STEPS];

endmodule

// ===== src/bcu_chk.sv =====
`timescale 1ns / 1ps
module bcu_chk import bcu_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [15:0]        in_raw_temperature,
  input logic [23:0]        in_raw_pressure,
  input logic               out_valid,
  input logic signed [15:0] out_temp_tenths,
  input logic [31:0]        out_pressure_pa,
  input logic               out_div_error,
  input logic               cfg_we,
  input logic [1:0]         cfg_index,
  input logic [63:0]        cfg_wdata
);

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_error |-> out_temp_tenths == 16'sd0 && out_pressure_pa == 32'd0)
    else $error("error item carries non-zero results");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching item");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

endmodule

bind barometric_compensation_unit bcu_chk u_bcu_chk (.*);
